FILE: rtl/line_pixel_stepper_assert.svh
// assertion macros for the line pixel stepper
`ifndef LINE_PIXEL_STEPPER_ASSERT_SVH
`define LINE_PIXEL_STEPPER_ASSERT_SVH
`ifndef SYNTHESIS
`define LPS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("line_pixel_stepper assertion failed");
`define LPS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("line_pixel_stepper assertion failed");
`else
`define LPS_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define LPS_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/lps_pkg.sv
// shared constants and types of the line pixel stepper
`default_nettype none
package lps_pkg;
  localparam int COORD_BITS_DEF = 12;
  localparam int DEPTH_BITS_DEF = 16;
  localparam int CH_BITS = 8;
  localparam int CHANNELS = 4;
  localparam int COLOUR_BITS = CH_BITS * CHANNELS;
  localparam int LANES = CHANNELS + 1;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic dividing;
    logic busy;
  } lps_status_t;
endpackage
`default_nettype wire

FILE: rtl/line_pixel_stepper.sv
// Bresenham line engine: a load transaction (tuser high) sets up a line and drops any line
// in progress; each tick transaction (tuser low) then yields one pixel, the end point not drawn,
// with depth and colour channels interpolated as floor((a*(n-i)+b*i)/n). Ticks stream at one
// pixel per cycle while the output is taken. A load with nonzero length is set up in the
// back end's restoring divider, one quotient bit per cycle for the depth and each of four
// colour channels; transactions behind it wait in a two-entry queue. A tick with no line
// running yields nothing.
`default_nettype none
module line_pixel_stepper #(
  parameter int COORD_BITS = lps_pkg::COORD_BITS_DEF,
  parameter int DEPTH_BITS = lps_pkg::DEPTH_BITS_DEF,
  localparam int IN_W  = ((4*COORD_BITS + 2*DEPTH_BITS + 2*lps_pkg::COLOUR_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((2*COORD_BITS + DEPTH_BITS + lps_pkg::COLOUR_BITS + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // x0, y0, x1, y1, z_a, z_b, col_a, col_b
  input  logic [IN_W-1:0]  s_tdata,
  // req_type
  input  logic             s_tuser,
  output logic             m_tvalid,
  input  logic             m_tready,
  // pix_x, pix_y, pix_depth, pix_colour
  output logic [OUT_W-1:0] m_tdata,
  output logic             m_tlast
);
  import lps_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int DB = DEPTH_BITS;
  localparam int CMD_W = 1 + 4*CB + 3 + 2*DB + 2*COLOUR_BITS;

  logic push, push_ready, pop_valid, cmd_pop;
  logic [CMD_W-1:0] push_data, pop_data;
  logic f_load, f_steep, f_cneg, f_rneg;
  logic [CB-1:0] f_x0, f_y0, f_span, f_minor;
  logic [DB-1:0] f_za, f_zb;
  logic [COLOUR_BITS-1:0] f_ca, f_cb;
  logic b_load, b_steep, b_cneg, b_rneg;
  logic [CB-1:0] b_x0, b_y0, b_span, b_minor;
  logic [DB-1:0] b_za, b_zb;
  logic [COLOUR_BITS-1:0] b_ca, b_cb;
  logic [CB-1:0] pix_x, pix_y;
  logic [DB-1:0] pix_depth;
  logic [COLOUR_BITS-1:0] pix_colour;
  lps_status_t status;

  lps_front #(.CB(CB), .DB(DB), .IN_W(IN_W)) u_front (
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .push(push), .push_ready(push_ready), .is_load(f_load), .x0(f_x0), .y0(f_y0),
    .span(f_span), .minor(f_minor), .steep(f_steep), .col_neg(f_cneg), .row_neg(f_rneg),
    .za(f_za), .zb(f_zb), .ca(f_ca), .cb(f_cb)
  );

  assign push_data = {f_load, f_x0, f_y0, f_span, f_minor, f_steep, f_cneg, f_rneg,
                      f_za, f_zb, f_ca, f_cb};

  lps_fifo #(.W(CMD_W)) u_queue (
    .clk(clk), .rst(rst), .push(push), .push_ready(push_ready), .push_data(push_data),
    .pop_valid(pop_valid), .pop(cmd_pop), .pop_data(pop_data)
  );

  assign {b_load, b_x0, b_y0, b_span, b_minor, b_steep, b_cneg, b_rneg,
          b_za, b_zb, b_ca, b_cb} = pop_data;

  lps_back #(.CB(CB), .DB(DB)) u_back (
    .clk(clk), .rst(rst), .cmd_valid(pop_valid), .cmd_pop(cmd_pop), .is_load(b_load),
    .x0(b_x0), .y0(b_y0), .span_in(b_span), .minor_in(b_minor), .steep_in(b_steep),
    .col_neg_in(b_cneg), .row_neg_in(b_rneg), .za(b_za), .zb(b_zb), .ca(b_ca), .cb(b_cb),
    .out_valid(m_tvalid), .out_ready(m_tready), .pix_x(pix_x), .pix_y(pix_y),
    .pix_depth(pix_depth), .pix_colour(pix_colour), .pix_last(m_tlast), .status(status)
  );

  assign m_tdata = OUT_W'({pix_colour, pix_depth, pix_y, pix_x});

`include "line_pixel_stepper_assert.svh"
  // queue is not popped while the divider runs
  `LPS_ASSERT_IMP(a_no_pop_in_div, clk, rst, status.dividing, !cmd_pop)
  // a tick with no line running makes no pixel
  `LPS_ASSERT_NXT(a_idle_tick_silent, clk, rst,
                  cmd_pop && !b_load && !status.busy && !m_tvalid, !m_tvalid)
endmodule
`default_nettype wire

FILE: rtl/lps_front.sv
// front end: accepts items and works out the line setup of load items
`default_nettype none
module lps_front #(
  parameter int CB = 12,
  parameter int DB = 16,
  parameter int IN_W = 144
) (
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [IN_W-1:0]      s_tdata,
  input  logic                 s_tuser,
  output logic                 push,
  input  logic                 push_ready,
  output logic                 is_load,
  output logic [CB-1:0]        x0,
  output logic [CB-1:0]        y0,
  output logic [CB-1:0]        span,
  output logic [CB-1:0]        minor,
  output logic                 steep,
  output logic                 col_neg,
  output logic                 row_neg,
  output logic [DB-1:0]        za,
  output logic [DB-1:0]        zb,
  output logic [lps_pkg::COLOUR_BITS-1:0] ca,
  output logic [lps_pkg::COLOUR_BITS-1:0] cb
);
  import lps_pkg::*;

  logic [CB-1:0] x1, y1, adx, ady;
  logic signed [CB:0] dx, dy;

  assign s_tready = push_ready;
  assign push     = s_tvalid && push_ready;
  assign is_load  = s_tuser;

  assign x0 = s_tdata[CB-1:0];
  assign y0 = s_tdata[2*CB-1:CB];
  assign x1 = s_tdata[3*CB-1:2*CB];
  assign y1 = s_tdata[4*CB-1:3*CB];
  assign za = s_tdata[4*CB+DB-1:4*CB];
  assign zb = s_tdata[4*CB+2*DB-1:4*CB+DB];
  assign ca = s_tdata[4*CB+2*DB+COLOUR_BITS-1:4*CB+2*DB];
  assign cb = s_tdata[4*CB+2*DB+2*COLOUR_BITS-1:4*CB+2*DB+COLOUR_BITS];

  always_comb begin
    dx = $signed({1'b0, x1}) - $signed({1'b0, x0});
    dy = $signed({1'b0, y1}) - $signed({1'b0, y0});
    adx = dx[CB] ? CB'(-dx) : dx[CB-1:0];
    ady = dy[CB] ? CB'(-dy) : dy[CB-1:0];
    col_neg = dx[CB];
    row_neg = dy[CB];
    // ties go to columns as major axis
    steep = ady > adx;
    span  = steep ? ady : adx;
    minor = steep ? adx : ady;
  end
endmodule
`default_nettype wire

FILE: rtl/lps_fifo.sv
// small command queue between front and back end
`default_nettype none
module lps_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop,
  output logic [W-1:0] pop_data
);
  import lps_pkg::*;

  logic [W-1:0] slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr, rptr;
  logic [QPTR_W:0] count;

  assign push_ready = count != (QPTR_W+1)'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop) rptr <= rptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/lps_back.sv
// back end: setup divider, bresenham stepper, interpolators and output register
`default_nettype none
module lps_back #(
  parameter int CB = 12,
  parameter int DB = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  output logic                 cmd_pop,
  input  logic                 is_load,
  input  logic [CB-1:0]        x0,
  input  logic [CB-1:0]        y0,
  input  logic [CB-1:0]        span_in,
  input  logic [CB-1:0]        minor_in,
  input  logic                 steep_in,
  input  logic                 col_neg_in,
  input  logic                 row_neg_in,
  input  logic [DB-1:0]        za,
  input  logic [DB-1:0]        zb,
  input  logic [lps_pkg::COLOUR_BITS-1:0] ca,
  input  logic [lps_pkg::COLOUR_BITS-1:0] cb,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [CB-1:0]        pix_x,
  output logic [CB-1:0]        pix_y,
  output logic [DB-1:0]        pix_depth,
  output logic [lps_pkg::COLOUR_BITS-1:0] pix_colour,
  output logic                 pix_last,
  output lps_pkg::lps_status_t status
);
  import lps_pkg::*;

  localparam int CNTW = $clog2(DB);
  localparam int LW = $clog2(LANES);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_STEP = 3'b100
  } state_t;

  state_t state;
  logic [CB-1:0] col, row, idx, span, minor;
  logic signed [CB+2:0] err;
  logic steep, col_neg, row_neg;
  logic [DB-1:0] a_end [LANES];
  logic [DB-1:0] b_end [LANES];
  logic signed [DB:0] qd [LANES];
  logic [CB-1:0] rd [LANES];
  logic signed [DB+1:0] q [LANES];
  logic [CB-1:0] r [LANES];
  logic [LW-1:0] lane;
  logic [CNTW-1:0] cnt;
  logic [CB-1:0] rem;
  logic [DB-1:0] quo;

  logic signed [DB:0] diff [LANES];
  logic [DB-1:0] mag [LANES];
  logic out_free, step_fire, load_fire, last_step, div_last;
  logic [CB:0] rs;
  logic ge;
  logic [CB-1:0] rem_next;
  logic [DB-1:0] quo_next;
  logic signed [DB:0] qd_next;
  logic [CB-1:0] rd_next;
  logic signed [CB+2:0] err_add, err_next;
  logic minor_step;
  logic [CB:0] r_sum [LANES];
  logic wrap [LANES];

  assign out_free  = !out_valid || out_ready;
  assign cmd_pop   = cmd_valid && (state != ST_DIV) &&
                     (is_load || state == ST_IDLE || out_free);
  assign load_fire = cmd_pop && is_load;
  assign step_fire = cmd_pop && !is_load && state == ST_STEP;
  assign last_step = (idx + 1'b1) == span;
  assign div_last  = cnt == CNTW'(DB-1);
  assign status.dividing = state == ST_DIV;
  assign status.busy     = state == ST_STEP;

  // restoring division of |b-a| by span, one quotient bit per cycle
  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      diff[k] = $signed({1'b0, b_end[k]}) - $signed({1'b0, a_end[k]});
      mag[k]  = diff[k][DB] ? DB'(-diff[k]) : diff[k][DB-1:0];
    end
    rs       = {rem, mag[lane][CNTW'(DB-1) - cnt]};
    ge       = rs >= {1'b0, span};
    rem_next = ge ? CB'(rs - {1'b0, span}) : rs[CB-1:0];
    quo_next = {quo[DB-2:0], ge};
    // floor division for a falling ramp: -quo-1 is the complement of quo
    if (diff[lane][DB] && rem_next != '0) begin
      qd_next = ~$signed({1'b0, quo_next});
      rd_next = span - rem_next;
    end else if (diff[lane][DB]) begin
      qd_next = -$signed({1'b0, quo_next});
      rd_next = rem_next;
    end else begin
      qd_next = $signed({1'b0, quo_next});
      rd_next = rem_next;
    end
  end

  always_comb begin
    err_add    = err + $signed({2'b0, minor, 1'b0});
    minor_step = err_add > $signed({3'b0, span});
    err_next   = minor_step ? err_add - $signed({2'b0, span, 1'b0}) : err_add;
    for (int k = 0; k < LANES; k++) begin
      r_sum[k] = {1'b0, r[k]} + {1'b0, rd[k]};
      wrap[k]  = r_sum[k] >= {1'b0, span};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else if (load_fire) begin
      state <= (span_in != '0) ? ST_DIV : ST_IDLE;
    end else if (state == ST_DIV && div_last && lane == LW'(LANES-1)) begin
      state <= ST_STEP;
    end else if (step_fire && last_step) begin
      state <= ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (load_fire) begin
      col     <= x0;
      row     <= y0;
      err     <= '0;
      idx     <= '0;
      span    <= span_in;
      minor   <= minor_in;
      steep   <= steep_in;
      col_neg <= col_neg_in;
      row_neg <= row_neg_in;
      a_end[0] <= za;
      b_end[0] <= zb;
      q[0]     <= $signed({2'b0, za});
      r[0]     <= '0;
      for (int k = 1; k < LANES; k++) begin
        a_end[k] <= DB'(ca[CH_BITS*(k-1) +: CH_BITS]);
        b_end[k] <= DB'(cb[CH_BITS*(k-1) +: CH_BITS]);
        q[k]     <= $signed({2'b0, DB'(ca[CH_BITS*(k-1) +: CH_BITS])});
        r[k]     <= '0;
      end
      lane <= '0;
      cnt  <= '0;
      rem  <= '0;
      quo  <= '0;
    end else if (state == ST_DIV) begin
      if (div_last) begin
        qd[lane] <= qd_next;
        rd[lane] <= rd_next;
        lane <= lane + 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quo  <= '0;
      end else begin
        cnt <= cnt + 1'b1;
        rem <= rem_next;
        quo <= quo_next;
      end
    end else if (step_fire) begin
      err <= err_next;
      idx <= idx + 1'b1;
      if (steep) begin
        row <= row_neg ? row - 1'b1 : row + 1'b1;
        if (minor_step) col <= col_neg ? col - 1'b1 : col + 1'b1;
      end else begin
        col <= col_neg ? col - 1'b1 : col + 1'b1;
        if (minor_step) row <= row_neg ? row - 1'b1 : row + 1'b1;
      end
      for (int k = 0; k < LANES; k++) begin
        r[k] <= wrap[k] ? CB'(r_sum[k] - {1'b0, span}) : r_sum[k][CB-1:0];
        q[k] <= q[k] + $signed({qd[k][DB], qd[k]}) +
                $signed({{(DB+1){1'b0}}, wrap[k]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire) begin
      pix_x     <= col;
      pix_y     <= row;
      pix_depth <= q[0][DB-1:0];
      for (int k = 1; k < LANES; k++) begin
        pix_colour[CH_BITS*(k-1) +: CH_BITS] <= q[k][CH_BITS-1:0];
      end
      pix_last  <= last_step;
    end
  end
endmodule
`default_nettype wire

FILE: bench/line_checker.sv
// pixel predictor and scoreboard for the line pixel stepper
`timescale 1ns / 1ps
`default_nettype none
module line_checker #(
  parameter int IN_W  = 144,
  parameter int OUT_W = 72
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              s_tvalid,
  input  wire              s_tready,
  input  wire [IN_W-1:0]   s_tdata,
  input  wire              s_tuser,
  input  wire              m_tvalid,
  input  wire              m_tready,
  input  wire [OUT_W-1:0]  m_tdata,
  input  wire              m_tlast,
  output int               fail_count,
  output int               pending,
  output int               pixel_count,
  output int               line_count
);
  typedef struct packed {
    logic        last;
    logic [31:0] colour;
    logic [15:0] depth;
    logic [11:0] y;
    logic [11:0] x;
  } pixel_t;

  pixel_t pixel_q[$];

  logic        running, steep, col_neg, row_neg;
  logic [11:0] cur_x, cur_y;
  int          err, idx, major, minor;
  logic [15:0] z_start, z_end;
  logic [31:0] c_start, c_end;

  function automatic logic [15:0] blend(input logic [15:0] a, input logic [15:0] b,
                                        input int i, input int n);
    longint unsigned num;
    num = longint'(a) * longint'(n - i) + longint'(b) * longint'(i);
    return 16'(num / longint'(n));
  endfunction

  function automatic logic [11:0] advance(input logic [11:0] v, input logic neg);
    return neg ? v - 12'd1 : v + 12'd1;
  endfunction

  task automatic accept_item(input logic [IN_W-1:0] d, input logic is_load);
    int dx, dy, ax, ay;
    pixel_t p;
    if (is_load) begin
      dx = int'(d[35:24]) - int'(d[11:0]);
      dy = int'(d[47:36]) - int'(d[23:12]);
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      col_neg = dx < 0;
      row_neg = dy < 0;
      steep = ay > ax;
      major = steep ? ay : ax;
      minor = steep ? ax : ay;
      cur_x = d[11:0];
      cur_y = d[23:12];
      err = 0;
      idx = 0;
      z_start = d[63:48];
      z_end = d[79:64];
      c_start = d[111:80];
      c_end = d[143:112];
      running = major != 0;
      line_count++;
    end else if (running) begin
      p.x = cur_x;
      p.y = cur_y;
      p.depth = blend(z_start, z_end, idx, major);
      for (int ch = 0; ch < 4; ch++)
        p.colour[8*ch +: 8] = 8'(blend(16'(c_start[8*ch +: 8]), 16'(c_end[8*ch +: 8]),
                                       idx, major));
      p.last = idx + 1 == major;
      pixel_q.push_back(p);
      err += 2 * minor;
      if (err > major) begin
        err -= 2 * major;
        if (steep) cur_x = advance(cur_x, col_neg);
        else cur_y = advance(cur_y, row_neg);
      end
      if (steep) cur_y = advance(cur_y, row_neg);
      else cur_x = advance(cur_x, col_neg);
      idx++;
      if (idx >= major) running = 0;
    end
  endtask

  always @(posedge clk) begin
    pixel_t got, want;
    if (rst) begin
      running <= 0;
      pixel_q.delete();
      fail_count <= 0;
      pixel_count <= 0;
      line_count <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = {m_tlast, m_tdata[71:0]};
        pixel_count++;
        if (pixel_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected pixel %h", got);
          fail_count++;
        end else begin
          want = pixel_q.pop_front();
          if (got !== want) begin
            if (fail_count < 10)
              $display({"pixel mismatch: expected x=%0d y=%0d z=%h c=%h l=%b, ",
                        "got x=%0d y=%0d z=%h c=%h l=%b"},
                       want.x, want.y, want.depth, want.colour, want.last,
                       got.x, got.y, got.depth, got.colour, got.last);
            fail_count++;
          end
        end
      end
      if (s_tvalid && s_tready) accept_item(s_tdata, s_tuser);
    end
    pending = pixel_q.size();
  end
endmodule
`default_nettype wire

FILE: bench/tb_top.sv
// stimulus and verdict for the line pixel stepper testbench
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  localparam int IN_W  = 144;
  localparam int OUT_W = 72;

  logic             clk = 0;
  logic             rst = 1;
  logic             s_tvalid = 0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;
  logic             s_tuser = 0;
  logic             m_tvalid;
  logic             m_tready = 0;
  logic [OUT_W-1:0] m_tdata;
  logic             m_tlast;
  int               fail_count, pending, pixel_count, line_count;
  int               send_idle, recv_stall;
  int               sent = 0;

  localparam logic TICK = 1'b0;
  localparam logic LOAD = 1'b1;

  always #10 clk = ~clk;

  line_pixel_stepper u_dut (.*);

  line_checker #(.IN_W(IN_W), .OUT_W(OUT_W)) u_chk (.*);

  always @(negedge clk) m_tready <= ($urandom_range(99) >= recv_stall);

  task automatic send(input logic kind, input logic [IN_W-1:0] d);
    while ($urandom_range(99) < send_idle) @(negedge clk);
    s_tvalid = 1;
    s_tuser = kind;
    s_tdata = d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
    @(negedge clk);
    s_tvalid = 0;
  endtask

  function automatic logic [IN_W-1:0] pack_line(input logic [11:0] xa, ya, xb, yb,
                                                input logic [15:0] za, zb,
                                                input logic [31:0] ca, cb);
    return {cb, ca, zb, za, yb, xb, ya, xa};
  endfunction

  task automatic load_line(input logic [11:0] xa, ya, xb, yb);
    send(LOAD, pack_line(xa, ya, xb, yb, 16'($urandom), 16'($urandom), $urandom, $urandom));
  endtask

  task automatic ticks(input int n);
    for (int i = 0; i < n; i++) send(TICK, IN_W'($urandom));
  endtask

  task automatic random_line;
    logic [11:0] xa, ya;
    int len;
    xa = 12'($urandom);
    ya = 12'($urandom);
    len = ($urandom_range(9) == 0) ? 300 : 12;
    load_line(xa, ya, 12'($urandom_range(len) + (xa > len ? xa - len : 0)),
              12'($urandom_range(len) + (ya > len ? ya - len : 0)));
    ticks($urandom_range(len + 4));
  endtask

  initial begin
    int items;
    send_idle = 0;
    recv_stall = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // directed: tick while idle, zero length, several octants, ties, extremes, abort
    ticks(2);
    load_line(12'd5, 12'd5, 12'd5, 12'd5);
    ticks(1);
    send(LOAD, pack_line(12'd0, 12'd0, 12'hfff, 12'hfff, 16'h0000, 16'hffff,
                         32'h0, 32'hffffffff));
    ticks(3);
    send(LOAD, pack_line(12'hfff, 12'd0, 12'd0, 12'd3, 16'hffff, 16'h0,
                         32'hffffffff, 32'h0));
    ticks(2);
    load_line(12'd10, 12'd10, 12'd14, 12'd12); ticks(5);
    load_line(12'd10, 12'd10, 12'd6, 12'd17);  ticks(8);
    load_line(12'd10, 12'd10, 12'd13, 12'd7);  ticks(3);
    load_line(12'd10, 12'd10, 12'd7, 12'd3);   ticks(8);
    wait (pending == 0);
    @(negedge clk);
    for (int ph = 0; ph < 4; ph++) begin
      send_idle  = (ph == 1) ? 84 : (ph == 3) ? 18 : 0;
      recv_stall = (ph == 2) ? 84 : (ph == 3) ? 18 : 0;
      items = sent;
      while (sent - items < 490) begin
        random_line();
        if ($urandom_range(30) == 0) begin
          wait (pending == 0);
          @(negedge clk);
        end
      end
      wait (pending == 0);
      @(negedge clk);
    end
    recv_stall = 0;
    wait (pending == 0);
    repeat (200) @(posedge clk);
    $display("covered %0d line loads and %0d pixels over four idle/stall mixes",
             line_count, pixel_count);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #50ms;
    $display("Regression FAIL");
    $finish;
  end
endmodule
`default_nettype wire

FILE: filelist.f
+incdir+rtl
rtl/lps_pkg.sv
rtl/lps_front.sv
rtl/lps_fifo.sv
rtl/lps_back.sv
rtl/line_pixel_stepper.sv
bench/line_checker.sv
bench/tb_top.sv
